// File: rtl/led_panel_xy_to_index_mapper_core_assert.svh
// Assertion macros used by the checker file of the LED panel mapper
`ifndef LED_PANEL_XY_TO_INDEX_MAPPER_CORE_ASSERT_SVH
`define LED_PANEL_XY_TO_INDEX_MAPPER_CORE_ASSERT_SVH

// clocked assertion, switched off while reset is high
`define LPM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define LPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/lpm_pkg.sv
// Types and constants of the LED panel coordinate mapper
package lpm_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int OFS_W      = 17;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_MAP  = 1'b1;

   localparam int FLAG_RIGHT  = 0;
   localparam int FLAG_BOTTOM = 1;
   localparam int FLAG_VERT   = 2;
   localparam int FLAG_SERP   = 3;

   localparam logic [OFS_W-1:0] OFS_SAT = OFS_W'(17'h10000);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GRID_WIDTH    = 3'd0,
      REG_GRID_HEIGHT   = 3'd1,
      REG_STRIP_LENGTH  = 3'd2,
      REG_FIRST_LED     = 3'd3,
      REG_REVERSE_ORDER = 3'd4,
      REG_BRIGHTNESS    = 3'd5,
      REG_PANEL_COUNT   = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic [8:0]  grid_width;
      logic [8:0]  grid_height;
      logic [15:0] strip_length;
      logic [15:0] first_led;
      logic        reverse_order;
      logic [7:0]  brightness;
      logic [2:0]  panel_count;
   } cfg_type;

   typedef struct packed {
      logic [7:0] left;
      logic [7:0] top;
      logic [8:0] width;
      logic [8:0] height;
      logic [3:0] flags;
   } panel_desc_type;

   typedef struct packed {
      logic             valid;
      logic             is_map;
      logic [7:0]       x;
      logic [7:0]       y;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic [1:0]       slot;
      logic             found;
      logic [OFS_W-1:0] offset;
      panel_desc_type   desc;
   } chain_item_type;

   typedef struct packed {
      logic        hit;
      logic [16:0] led_index;
      logic [7:0]  red_out;
      logic [7:0]  green_out;
      logic [7:0]  blue_out;
   } rsp_payload_type;

endpackage

// File: rtl/lpm_if.sv
// Channel interfaces of the LED panel coordinate mapper
interface lpm_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] pixel_x;
   logic [7:0] pixel_y;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   logic [1:0] panel_slot;
   logic [7:0] panel_left;
   logic [7:0] panel_top;
   logic [8:0] panel_width;
   logic [8:0] panel_height;
   logic [3:0] panel_flags;

   modport source (
      output valid, action, pixel_x, pixel_y, red_in, green_in, blue_in, panel_slot,
             panel_left, panel_top, panel_width, panel_height, panel_flags,
      input  ready
   );
   modport sink (
      input  valid, action, pixel_x, pixel_y, red_in, green_in, blue_in, panel_slot,
             panel_left, panel_top, panel_width, panel_height, panel_flags,
      output ready
   );
endinterface

interface lpm_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [16:0] led_index;
   logic [7:0]  red_out;
   logic [7:0]  green_out;
   logic [7:0]  blue_out;

   modport source (output valid, hit, led_index, red_out, green_out, blue_out, input ready);
   modport sink (input valid, hit, led_index, red_out, green_out, blue_out, output ready);
endinterface

interface lpm_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/led_panel_xy_to_index_mapper_core.sv
// Top level of the LED panel coordinate mapper: registers, panel chain and back end
//
//  channel  | role     | handshake    | carries
//  req_chan | in, item | valid/ready  | load descriptor or map pixel
//  rsp_chan | out      | valid/ready  | hit, led_index, scaled colour
//  csr_chan | in       | valid/ready  | register index and data, always ready
//
// One item enters per cycle unless the result stalls; a map item's result passes through
// the panel chain (one cell per panel) and four back end stages.
// Load items flow through the chain and write their slot on arrival; they give no result.
// A stalled result holds the whole pipeline; req ready is low only then.
// Reset clears the control state and registers; the panel table is undefined until loaded.
module led_panel_xy_to_index_mapper_core #(
   parameter int NUM_PANELS = 4,
   parameter int COORD_BITS = 8
) (
   input logic          clock,
   input logic          reset,
   lpm_req_if.sink      req_chan,
   lpm_rsp_if.source    rsp_chan,
   lpm_csr_if.sink      csr_chan
);
   import lpm_pkg::*;

   localparam int         CW         = (COORD_BITS < 8) ? COORD_BITS : 8;
   localparam logic [7:0] COORD_MASK = 8'((1 << CW) - 1);

   cfg_type         cfg_ff;
   cfg_type         cfg_in;
   logic            adv;
   logic            fin_valid;
   rsp_payload_type fin_data;
   chain_item_type  chain [NUM_PANELS+1];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_GRID_WIDTH:    cfg_in.grid_width    = csr_chan.data[8:0];
            REG_GRID_HEIGHT:   cfg_in.grid_height   = csr_chan.data[8:0];
            REG_STRIP_LENGTH:  cfg_in.strip_length  = csr_chan.data;
            REG_FIRST_LED:     cfg_in.first_led     = csr_chan.data;
            REG_REVERSE_ORDER: cfg_in.reverse_order = csr_chan.data[0];
            REG_BRIGHTNESS:    cfg_in.brightness    = csr_chan.data[7:0];
            REG_PANEL_COUNT:   cfg_in.panel_count   = csr_chan.data[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width    <= 9'd16;
         cfg_ff.grid_height   <= 9'd16;
         cfg_ff.strip_length  <= 16'd256;
         cfg_ff.first_led     <= 16'd0;
         cfg_ff.reverse_order <= 1'b0;
         cfg_ff.brightness    <= 8'd255;
         cfg_ff.panel_count   <= 3'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_chan.ready = 1'b1;

   assign adv            = !fin_valid || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_comb begin
      chain[0]              = '0;
      chain[0].valid        = req_chan.valid;
      chain[0].is_map       = (req_chan.action == ACT_MAP);
      chain[0].x            = req_chan.pixel_x & COORD_MASK;
      chain[0].y            = req_chan.pixel_y & COORD_MASK;
      chain[0].red          = req_chan.red_in;
      chain[0].green        = req_chan.green_in;
      chain[0].blue         = req_chan.blue_in;
      chain[0].slot         = req_chan.panel_slot;
      if (req_chan.action == ACT_LOAD) begin
         chain[0].desc.left   = req_chan.panel_left;
         chain[0].desc.top    = req_chan.panel_top;
         chain[0].desc.width  = req_chan.panel_width;
         chain[0].desc.height = req_chan.panel_height;
         chain[0].desc.flags  = req_chan.panel_flags;
      end
   end

   for (genvar i = 0; i < NUM_PANELS; i++) begin : g_cell
      lpm_cell #(
         .CELL_IDX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .adv         (adv),
         .panel_count (cfg_ff.panel_count),
         .up_item     (chain[i]),
         .dn_item     (chain[i+1])
      );
   end

   lpm_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg_ff),
      .item      (chain[NUM_PANELS]),
      .rsp_valid (fin_valid),
      .rsp_data  (fin_data)
   );

   assign rsp_chan.valid     = fin_valid;
   assign rsp_chan.hit       = fin_data.hit;
   assign rsp_chan.led_index = fin_data.led_index;
   assign rsp_chan.red_out   = fin_data.red_out;
   assign rsp_chan.green_out = fin_data.green_out;
   assign rsp_chan.blue_out  = fin_data.blue_out;

endmodule

// File: rtl/lpm_cell.sv
// One panel cell of the search chain: holds a descriptor, tests and forwards the item
module lpm_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic [2:0]             panel_count,
   input  lpm_pkg::chain_item_type up_item,
   output lpm_pkg::chain_item_type dn_item
);
   import lpm_pkg::*;

   panel_desc_type desc_ff;
   logic [17:0]    area_ff;
   chain_item_type item_ff;
   chain_item_type item_in;

   logic           load_hit;
   logic           active;
   logic           holds;
   logic [9:0]     x_end;
   logic [9:0]     y_end;
   logic [18:0]    ofs_sum;

   assign load_hit = up_item.valid && !up_item.is_map && ({2'b00, up_item.slot} == 4'(CELL_IDX));
   assign active   = {1'b0, panel_count} > 4'(CELL_IDX);
   assign x_end    = {2'b00, desc_ff.left} + {1'b0, desc_ff.width};
   assign y_end    = {2'b00, desc_ff.top} + {1'b0, desc_ff.height};
   assign holds    = active
                   && (up_item.x >= desc_ff.left) && ({2'b00, up_item.x} < x_end)
                   && (up_item.y >= desc_ff.top)  && ({2'b00, up_item.y} < y_end);
   assign ofs_sum  = {2'b00, up_item.offset} + {1'b0, area_ff};

   always_comb begin
      item_in = up_item;
      if (up_item.is_map && !up_item.found) begin
         if (holds) begin
            item_in.found = 1'b1;
            item_in.desc  = desc_ff;
         end else if (active) begin
            item_in.offset = (ofs_sum[18:16] != 3'd0) ? OFS_SAT : ofs_sum[OFS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && load_hit) begin
         desc_ff <= up_item.desc;
         area_ff <= up_item.desc.width * up_item.desc.height;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (adv) begin
         item_ff <= item_in;
      end
   end

   assign dn_item = item_ff;

endmodule

// File: rtl/lpm_finish.sv
// Back end: local coordinates, strip order, index bounds and colour scaling
module lpm_finish (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  lpm_pkg::cfg_type        cfg,
   input  lpm_pkg::chain_item_type item,
   output logic                    rsp_valid,
   output lpm_pkg::rsp_payload_type rsp_data
);
   import lpm_pkg::*;

   function automatic logic [7:0] div_full(input logic [15:0] p);
      logic [16:0] t;
      t = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
      return t[15:8];
   endfunction

   logic [8:0] lx;
   logic [8:0] ly;
   logic [8:0] xp;
   logic [8:0] yp;
   logic [8:0] strip_in;
   logic [8:0] pos_pre;
   logic [8:0] slen_in;
   logic [8:0] pos_in;
   logic       in_grid;

   logic             s1_valid_ff;
   logic             s1_ok_ff;
   logic [8:0]       s1_strip_ff;
   logic [8:0]       s1_slen_ff;
   logic [8:0]       s1_pos_ff;
   logic [OFS_W-1:0] s1_offset_ff;
   logic [7:0]       s1_red_ff;
   logic [7:0]       s1_green_ff;
   logic [7:0]       s1_blue_ff;

   logic             s2_valid_ff;
   logic             s2_ok_ff;
   logic [17:0]      s2_prod_ff;
   logic [8:0]       s2_pos_ff;
   logic [OFS_W-1:0] s2_offset_ff;
   logic [15:0]      s2_red_ff;
   logic [15:0]      s2_green_ff;
   logic [15:0]      s2_blue_ff;

   logic [18:0]      pix;
   logic             s3_valid_ff;
   logic             s3_hit_ff;
   logic [15:0]      s3_pix_ff;
   logic [7:0]       s3_red_ff;
   logic [7:0]       s3_green_ff;
   logic [7:0]       s3_blue_ff;

   logic [15:0]      strip_pos;
   logic [16:0]      led_sum;
   logic             rsp_valid_ff;
   rsp_payload_type  rsp_ff;
   rsp_payload_type  rsp_in;

   always_comb begin
      lx       = {1'b0, item.x} - {1'b0, item.desc.left};
      ly       = {1'b0, item.y} - {1'b0, item.desc.top};
      xp       = item.desc.flags[FLAG_RIGHT]  ? (item.desc.width - 9'd1 - lx)  : lx;
      yp       = item.desc.flags[FLAG_BOTTOM] ? (item.desc.height - 9'd1 - ly) : ly;
      strip_in = item.desc.flags[FLAG_VERT] ? xp : yp;
      pos_pre  = item.desc.flags[FLAG_VERT] ? yp : xp;
      slen_in  = item.desc.flags[FLAG_VERT] ? item.desc.height : item.desc.width;
      pos_in   = (item.desc.flags[FLAG_SERP] && strip_in[0]) ? (slen_in - 9'd1 - pos_pre)
                                                             : pos_pre;
      in_grid  = ({1'b0, item.x} < cfg.grid_width) && ({1'b0, item.y} < cfg.grid_height);
   end

   assign pix = {2'b00, s2_offset_ff} + {1'b0, s2_prod_ff} + {10'd0, s2_pos_ff};

   always_comb begin
      strip_pos = cfg.reverse_order ? (cfg.strip_length - 16'd1 - s3_pix_ff) : s3_pix_ff;
      led_sum   = {1'b0, cfg.first_led} + {1'b0, strip_pos};
      rsp_in    = '0;
      if (s3_hit_ff) begin
         rsp_in.hit       = 1'b1;
         rsp_in.led_index = led_sum;
         rsp_in.red_out   = s3_red_ff;
         rsp_in.green_out = s3_green_ff;
         rsp_in.blue_out  = s3_blue_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= item.valid && item.is_map;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ok_ff     <= item.found && in_grid;
         s1_strip_ff  <= strip_in;
         s1_slen_ff   <= slen_in;
         s1_pos_ff    <= pos_in;
         s1_offset_ff <= item.offset;
         s1_red_ff    <= item.red;
         s1_green_ff  <= item.green;
         s1_blue_ff   <= item.blue;

         s2_ok_ff     <= s1_ok_ff;
         s2_prod_ff   <= s1_strip_ff * s1_slen_ff;
         s2_pos_ff    <= s1_pos_ff;
         s2_offset_ff <= s1_offset_ff;
         s2_red_ff    <= s1_red_ff * cfg.brightness;
         s2_green_ff  <= s1_green_ff * cfg.brightness;
         s2_blue_ff   <= s1_blue_ff * cfg.brightness;

         s3_hit_ff    <= s2_ok_ff && (pix < {3'b000, cfg.strip_length});
         s3_pix_ff    <= pix[15:0];
         s3_red_ff    <= div_full(s2_red_ff);
         s3_green_ff  <= div_full(s2_green_ff);
         s3_blue_ff   <= div_full(s2_blue_ff);

         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/lpm_checker.sv
// Port checker of the LED panel coordinate mapper and its bind to the top level
`include "led_panel_xy_to_index_mapper_core_assert.svh"

module lpm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic [16:0] rsp_led_index,
   input logic [7:0]  rsp_red,
   input logic [7:0]  rsp_green,
   input logic [7:0]  rsp_blue
);

   logic        stall;
   logic [41:0] rsp_word;
   logic        rsp_zero;

   assign stall    = rsp_valid && !rsp_ready;
   assign rsp_word = {rsp_hit, rsp_led_index, rsp_red, rsp_green, rsp_blue};
   assign rsp_zero = (rsp_word[40:0] == 41'd0);

   `LPM_ASSERT(a_rsp_hold, clock, reset, stall |=> rsp_valid && $stable(rsp_word), "result not held")
   `LPM_ASSERT(a_miss_zero, clock, reset, rsp_valid && !rsp_hit |-> rsp_zero, "miss result not zero")
   `LPM_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready, "not ready with empty output")
   `LPM_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind led_panel_xy_to_index_mapper_core lpm_checker u_lpm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_hit       (rsp_chan.hit),
   .rsp_led_index (rsp_chan.led_index),
   .rsp_red       (rsp_chan.red_out),
   .rsp_green     (rsp_chan.green_out),
   .rsp_blue      (rsp_chan.blue_out)
);

// File: sim/testbench.sv
// Testbench of the LED panel mapper: directed cases then random streams against a shadow model
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lpm_pkg::*;

   localparam int          HALF_PERIOD    = 1;
   localparam int          RESET_CYCLES   = 3;
   localparam int          NUM_SLOTS      = 4;
   localparam int          DRAIN_CYCLES   = NUM_SLOTS + 8;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          MAX_GAP        = 16;
   localparam int          MAX_REPORTS    = 40;
   localparam int unsigned FULL_SCALE     = 255;

   localparam logic [3:0] F_NONE   = 4'b0000;
   localparam logic [3:0] F_RIGHT  = 4'(1 << FLAG_RIGHT);
   localparam logic [3:0] F_BOTTOM = 4'(1 << FLAG_BOTTOM);
   localparam logic [3:0] F_VERT   = 4'(1 << FLAG_VERT);
   localparam logic [3:0] F_SERP   = 4'(1 << FLAG_SERP);

   typedef struct {
      logic           action;
      logic [7:0]     x;
      logic [7:0]     y;
      logic [7:0]     red;
      logic [7:0]     green;
      logic [7:0]     blue;
      logic [1:0]     slot;
      panel_desc_type desc;
   } led_request_type;

   logic clock = 1'b0;
   logic reset;

   lpm_req_if req_chan ();
   lpm_rsp_if rsp_chan ();
   lpm_csr_if csr_chan ();

   led_panel_xy_to_index_mapper_core #(
      .NUM_PANELS(NUM_SLOTS),
      .COORD_BITS(8)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   cfg_type         cfg_shadow;
   panel_desc_type  panel_shadow [NUM_SLOTS];
   rsp_payload_type awaited_pixels [$];
   int unsigned     mismatch_count = 0;
   int unsigned     quiet_cycles   = 0;
   int unsigned     send_idle_pct  = 0;
   int unsigned     stall_pct      = 0;

   always #(HALF_PERIOD) clock = ~clock;

   function automatic logic [7:0] scale_channel(input logic [7:0] c);
      return 8'((int'(c) * int'(cfg_shadow.brightness)) / FULL_SCALE);
   endfunction

   function automatic rsp_payload_type map_pixel(input led_request_type r);
      rsp_payload_type res;
      int unsigned     px, py, searched, offset, i;
      int unsigned     pl, pt, pw, ph, lx, ly, xp, yp, strip_idx, pos, slen, pix;
      logic [3:0]      fl;
      bit              found;
      res = '0;
      px = int'(r.x);
      py = int'(r.y);
      if (px >= int'(cfg_shadow.grid_width) || py >= int'(cfg_shadow.grid_height)) return res;
      searched = (int'(cfg_shadow.panel_count) > NUM_SLOTS) ? NUM_SLOTS
                                                           : int'(cfg_shadow.panel_count);
      offset = 0;
      found = 1'b0;
      pl = 0;
      pt = 0;
      pw = 0;
      ph = 0;
      for (i = 0; i < searched; i++) begin
         pl = int'(panel_shadow[i].left);
         pt = int'(panel_shadow[i].top);
         pw = int'(panel_shadow[i].width);
         ph = int'(panel_shadow[i].height);
         if (px >= pl && px < pl + pw && py >= pt && py < pt + ph) begin
            found = 1'b1;
            break;
         end
         offset += pw * ph;
      end
      if (!found) return res;
      fl = panel_shadow[i].flags;
      lx = px - pl;
      ly = py - pt;
      xp = fl[FLAG_RIGHT] ? pw - 1 - lx : lx;
      yp = fl[FLAG_BOTTOM] ? ph - 1 - ly : ly;
      if (fl[FLAG_VERT]) begin
         strip_idx = xp;
         pos = yp;
         slen = ph;
      end else begin
         strip_idx = yp;
         pos = xp;
         slen = pw;
      end
      if (fl[FLAG_SERP] && (strip_idx % 2) == 1) pos = slen - 1 - pos;
      pix = offset + strip_idx * slen + pos;
      if (pix >= int'(cfg_shadow.strip_length)) return res;
      if (cfg_shadow.reverse_order) pix = int'(cfg_shadow.strip_length) - 1 - pix;
      res.hit       = 1'b1;
      res.led_index = 17'(int'(cfg_shadow.first_led) + pix);
      res.red_out   = scale_channel(r.red);
      res.green_out = scale_channel(r.green);
      res.blue_out  = scale_channel(r.blue);
      return res;
   endfunction

   function automatic int unsigned pick_grid_size();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10) return 256;
      if (roll < 20) return $urandom_range(256, 1);
      return $urandom_range(32, 1);
   endfunction

   function automatic int unsigned pick_span();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 6) return 0;
      if (roll < 14) return $urandom_range(256, 1);
      return $urandom_range(16, 1);
   endfunction

   function automatic panel_desc_type random_panel(input int unsigned gw, input int unsigned gh);
      panel_desc_type pd;
      pd.left   = 8'(($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(gw - 1));
      pd.top    = 8'(($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(gh - 1));
      pd.width  = 9'(pick_span());
      pd.height = 9'(pick_span());
      pd.flags  = 4'($urandom_range(15));
      return pd;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("%0t ns: mismatch, %s", $time, msg);
   endtask

   task automatic compare_field(input string field, input logic [16:0] got,
                                input logic [16:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %0h, wanted %0h", field, got, want));
   endtask

   task automatic push_request(input led_request_type r);
      int unsigned gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.action       <= r.action;
      req_chan.pixel_x      <= r.x;
      req_chan.pixel_y      <= r.y;
      req_chan.red_in       <= r.red;
      req_chan.green_in     <= r.green;
      req_chan.blue_in      <= r.blue;
      req_chan.panel_slot   <= r.slot;
      req_chan.panel_left   <= r.desc.left;
      req_chan.panel_top    <= r.desc.top;
      req_chan.panel_width  <= r.desc.width;
      req_chan.panel_height <= r.desc.height;
      req_chan.panel_flags  <= r.desc.flags;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (r.action == ACT_LOAD) begin
         panel_shadow[r.slot] = r.desc;
      end else begin
         awaited_pixels.push_back(map_pixel(r));
      end
   endtask

   task automatic send_map(input int unsigned x, input int unsigned y, input int unsigned red,
                           input int unsigned green, input int unsigned blue);
      led_request_type r;
      r.action = ACT_MAP;
      r.x      = 8'(x);
      r.y      = 8'(y);
      r.red    = 8'(red);
      r.green  = 8'(green);
      r.blue   = 8'(blue);
      r.slot   = 2'($urandom_range(3));
      r.desc   = panel_desc_type'(38'({$urandom, $urandom}));
      push_request(r);
   endtask

   task automatic send_load(input int unsigned slot, input int unsigned left,
                            input int unsigned top, input int unsigned width,
                            input int unsigned height, input logic [3:0] flags);
      led_request_type r;
      r.action      = ACT_LOAD;
      r.x           = 8'($urandom);
      r.y           = 8'($urandom);
      r.red         = 8'($urandom);
      r.green       = 8'($urandom);
      r.blue        = 8'($urandom);
      r.slot        = 2'(slot);
      r.desc.left   = 8'(left);
      r.desc.top    = 8'(top);
      r.desc.width  = 9'(width);
      r.desc.height = 9'(height);
      r.desc.flags  = flags;
      push_request(r);
   endtask

   task automatic write_reg(input csr_reg_type idx, input int unsigned value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= 16'(value);
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      case (idx)
         REG_GRID_WIDTH:    cfg_shadow.grid_width    = 9'(value);
         REG_GRID_HEIGHT:   cfg_shadow.grid_height   = 9'(value);
         REG_STRIP_LENGTH:  cfg_shadow.strip_length  = 16'(value);
         REG_FIRST_LED:     cfg_shadow.first_led     = 16'(value);
         REG_REVERSE_ORDER: cfg_shadow.reverse_order = 1'(value);
         REG_BRIGHTNESS:    cfg_shadow.brightness    = 8'(value);
         REG_PANEL_COUNT:   cfg_shadow.panel_count   = 3'(value);
         default: ;
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic settle_pipeline();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (awaited_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_values();
      send_map(0, 0, 255, 255, 255);
      send_load(0, 0, 0, 8, 8, F_NONE);
      send_load(1, 8, 0, 8, 8, F_RIGHT | F_SERP);
      send_load(2, 0, 8, 8, 8, F_VERT | F_BOTTOM);
      send_load(3, 8, 8, 256, 256, F_RIGHT | F_BOTTOM | F_VERT | F_SERP);
      settle_pipeline();
      write_reg(REG_PANEL_COUNT, 4);
      send_map(3, 5, 255, 0, 128);
      send_map(15, 15, 1, 2, 3);
      send_map(16, 0, 9, 9, 9);
   endtask

   task automatic test_panel_orientation();
      send_map(12, 2, 10, 20, 30);
      send_map(12, 3, 10, 20, 30);
      send_map(5, 13, 10, 20, 30);
      settle_pipeline();
      write_reg(REG_GRID_WIDTH, 256);
      write_reg(REG_GRID_HEIGHT, 256);
      write_reg(REG_STRIP_LENGTH, 65535);
      send_map(255, 255, 200, 100, 50);
      send_map(0, 255, 200, 100, 50);
      send_load(2, 0, 0, 16, 16, F_SERP);
      send_load(1, 8, 0, 0, 8, F_NONE);
      send_map(3, 3, 77, 88, 99);
      send_map(12, 3, 77, 88, 99);
      send_map(2, 12, 77, 88, 99);
   endtask

   task automatic test_register_extremes();
      settle_pipeline();
      write_reg(REG_GRID_WIDTH, 0);
      send_map(0, 0, 1, 1, 1);
      settle_pipeline();
      write_reg(REG_GRID_WIDTH, 256);
      write_reg(REG_GRID_HEIGHT, 0);
      send_map(0, 0, 1, 1, 1);
      settle_pipeline();
      write_reg(REG_GRID_HEIGHT, 256);
      write_reg(REG_STRIP_LENGTH, 0);
      send_map(0, 0, 1, 1, 1);
      settle_pipeline();
      write_reg(REG_STRIP_LENGTH, 65535);
      write_reg(REG_FIRST_LED, 65535);
      write_reg(REG_REVERSE_ORDER, 1);
      write_reg(REG_BRIGHTNESS, 0);
      send_map(255, 255, 255, 255, 255);
      settle_pipeline();
      write_reg(REG_BRIGHTNESS, 1);
      write_reg(REG_PANEL_COUNT, 7);
      send_map(3, 3, 255, 254, 128);
      settle_pipeline();
      write_reg(REG_BRIGHTNESS, 128);
      write_reg(REG_REVERSE_ORDER, 0);
      write_reg(REG_FIRST_LED, 0);
      write_reg(REG_PANEL_COUNT, 0);
      send_map(3, 3, 255, 254, 128);
   endtask

   task automatic test_random_streams(input int unsigned idle_pct, input int unsigned hold_pct,
                                      input int unsigned layouts, input int unsigned items);
      int unsigned    gw, gh, total, cap, roll, s, live, x, y;
      bit             tiled;
      panel_desc_type layout [NUM_SLOTS];
      panel_desc_type pd;
      send_idle_pct = idle_pct;
      stall_pct = hold_pct;
      repeat (layouts) begin
         settle_pipeline();
         gw = pick_grid_size();
         gh = pick_grid_size();
         tiled = 1'($urandom_range(1));
         total = 0;
         for (s = 0; s < NUM_SLOTS; s++) begin
            if (tiled) begin
               layout[s].left   = 8'((s % 2 == 1) ? gw / 2 : 0);
               layout[s].top    = 8'((s / 2 == 1) ? gh / 2 : 0);
               layout[s].width  = 9'((s % 2 == 1) ? gw - gw / 2 : gw / 2);
               layout[s].height = 9'((s / 2 == 1) ? gh - gh / 2 : gh / 2);
               layout[s].flags  = 4'($urandom_range(15));
            end else begin
               layout[s] = random_panel(gw, gh);
            end
            total += int'(layout[s].width) * int'(layout[s].height);
         end
         cap = (total > 65535) ? 65535 : total;
         roll = $urandom_range(99);
         write_reg(REG_GRID_WIDTH, gw);
         write_reg(REG_GRID_HEIGHT, gh);
         write_reg(REG_STRIP_LENGTH, (roll < 40) ? 65535 : (roll < 80) ? cap
                                                                    : $urandom_range(cap));
         write_reg(REG_FIRST_LED, ($urandom_range(1) == 0) ? 0 : $urandom_range(65535));
         write_reg(REG_REVERSE_ORDER, $urandom_range(1));
         roll = $urandom_range(99);
         write_reg(REG_BRIGHTNESS, (roll < 20) ? 255 : (roll < 30) ? 0 : $urandom_range(255));
         write_reg(REG_PANEL_COUNT, ($urandom_range(99) < 70) ? 4 : $urandom_range(7));
         for (s = 0; s < NUM_SLOTS; s++) begin
            send_load(s, layout[s].left, layout[s].top, layout[s].width, layout[s].height,
                      layout[s].flags);
         end
         live = (int'(cfg_shadow.panel_count) > NUM_SLOTS) ? NUM_SLOTS
                                                          : int'(cfg_shadow.panel_count);
         repeat (items) begin
            roll = $urandom_range(99);
            if (roll < 6) begin
               pd = random_panel(gw, gh);
               send_load($urandom_range(NUM_SLOTS - 1), pd.left, pd.top, pd.width, pd.height,
                         pd.flags);
            end else if (roll < 80 && live > 0) begin
               pd = panel_shadow[$urandom_range(live - 1)];
               x = int'(pd.left) + ((pd.width != 0) ? $urandom_range(int'(pd.width) - 1) : 0);
               y = int'(pd.top) + ((pd.height != 0) ? $urandom_range(int'(pd.height) - 1) : 0);
               send_map(x, y, $urandom_range(255), $urandom_range(255), $urandom_range(255));
            end else begin
               x = ($urandom_range(9) < 7) ? $urandom_range(gw - 1) : $urandom_range(255);
               y = ($urandom_range(9) < 7) ? $urandom_range(gh - 1) : $urandom_range(255);
               send_map(x, y, $urandom_range(255), $urandom_range(255), $urandom_range(255));
            end
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (awaited_pixels.size() == 0) begin
            report_mismatch("result with no map item waiting");
         end else begin
            want = awaited_pixels.pop_front();
            compare_field("hit", 17'(rsp_chan.hit), 17'(want.hit));
            compare_field("led_index", rsp_chan.led_index, want.led_index);
            compare_field("red_out", 17'(rsp_chan.red_out), 17'(want.red_out));
            compare_field("green_out", 17'(rsp_chan.green_out), 17'(want.green_out));
            compare_field("blue_out", 17'(rsp_chan.blue_out), 17'(want.blue_out));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
                || (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
                || (csr_chan.valid === 1'b1 && csr_chan.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.action       = ACT_LOAD;
      req_chan.pixel_x      = '0;
      req_chan.pixel_y      = '0;
      req_chan.red_in       = '0;
      req_chan.green_in     = '0;
      req_chan.blue_in      = '0;
      req_chan.panel_slot   = '0;
      req_chan.panel_left   = '0;
      req_chan.panel_top    = '0;
      req_chan.panel_width  = '0;
      req_chan.panel_height = '0;
      req_chan.panel_flags  = '0;
      rsp_chan.ready        = 1'b1;
      csr_chan.valid        = 1'b0;
      csr_chan.index        = REG_GRID_WIDTH;
      csr_chan.data         = '0;
      cfg_shadow.grid_width    = 9'd16;
      cfg_shadow.grid_height   = 9'd16;
      cfg_shadow.strip_length  = 16'd256;
      cfg_shadow.first_led     = 16'd0;
      cfg_shadow.reverse_order = 1'b0;
      cfg_shadow.brightness    = 8'd255;
      cfg_shadow.panel_count   = 3'd0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_panel_orientation();
      test_register_extremes();
      test_random_streams(0, 0, 4, 86);
      test_random_streams(66, 0, 4, 86);
      test_random_streams(0, 66, 4, 86);
      test_random_streams(24, 24, 4, 86);

      send_idle_pct = 0;
      stall_pct = 0;
      settle_pipeline();
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
